// ===== sv/md5_pkg.sv =====
// Shared types, constants and the message index function of the MD5 hash engine.
package md5_pkg;

  // Initial chaining values, word 0 first.
  localparam logic [31:0] MD5_IV [4] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476
  };

  // Byte that opens the padding.
  localparam logic [7:0] PAD_BYTE = 8'h80;

  // Per-round additive constants.
  localparam logic [31:0] MD5_K [64] = '{
    32'hD76AA478, 32'hE8C7B756, 32'h242070DB, 32'hC1BDCEEE,
    32'hF57C0FAF, 32'h4787C62A, 32'hA8304613, 32'hFD469501,
    32'h698098D8, 32'h8B44F7AF, 32'hFFFF5BB1, 32'h895CD7BE,
    32'h6B901122, 32'hFD987193, 32'hA679438E, 32'h49B40821,
    32'hF61E2562, 32'hC040B340, 32'h265E5A51, 32'hE9B6C7AA,
    32'hD62F105D, 32'h02441453, 32'hD8A1E681, 32'hE7D3FBC8,
    32'h21E1CDE6, 32'hC33707D6, 32'hF4D50D87, 32'h455A14ED,
    32'hA9E3E905, 32'hFCEFA3F8, 32'h676F02D9, 32'h8D2A4C8A,
    32'hFFFA3942, 32'h8771F681, 32'h6D9D6122, 32'hFDE5380C,
    32'hA4BEEA44, 32'h4BDECFA9, 32'hF6BB4B60, 32'hBEBFBC70,
    32'h289B7EC6, 32'hEAA127FA, 32'hD4EF3085, 32'h04881D05,
    32'hD9D4D039, 32'hE6DB99E5, 32'h1FA27CF8, 32'hC4AC5665,
    32'hF4292244, 32'h432AFF97, 32'hAB9423A7, 32'hFC93A039,
    32'h655B59C3, 32'h8F0CCC92, 32'hFFEFF47D, 32'h85845DD1,
    32'h6FA87E4F, 32'hFE2CE6E0, 32'hA3014314, 32'h4E0811A1,
    32'hF7537E82, 32'hBD3AF235, 32'h2AD7D2BB, 32'hEB86D391
  };

  // Rotate amounts, indexed by {round group, round modulo 4}.
  localparam logic [4:0] MD5_S [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  // Depth of the word queue between the front and the back.
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);

  // One little-endian message word on its way to the compressor.
  typedef struct packed {
    logic        msg_end;  // word 15 of the final block of a message
    logic [31:0] word;
  } md5_word_t;

  // Message word selected in a given round.
  function automatic logic [3:0] md5_msg_idx(input logic [5:0] rnd);
    logic [3:0] lo;
    logic [3:0] idx;
    lo = rnd[3:0];
    case (rnd[5:4])
      2'd0:    idx = lo;
      2'd1:    idx = lo * 4'd5 + 4'd1;
      2'd2:    idx = lo * 4'd3 + 4'd5;
      default: idx = lo * 4'd7;
    endcase
    return idx;
  endfunction

endpackage

// ===== sv/md5_front.sv =====
// Front end: packs message bytes into words, counts length and generates padding.
module md5_front import md5_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // has_byte
  input  logic        in_tlast,   // last
  output logic        q_push,
  output md5_word_t   q_word,
  input  logic        q_full
);

  typedef enum logic [1:0] {
    F_ACCEPT = 2'b01,
    F_PAD    = 2'b10
  } fst_t;

  fst_t        fst_r, fst_nxt;
  logic [5:0]  fill_r, fill_nxt;
  logic [63:0] bitlen_r, bitlen_nxt;
  logic [31:0] word_r, word_nxt;
  logic        mark_r, mark_nxt;
  logic        len_ok_r, len_ok_nxt;

  logic [1:0]  lane;
  logic [3:0]  wi;
  logic [4:0]  lane_sh;
  logic [31:0] byte_word;
  logic [31:0] keep_mask;
  logic [31:0] pad_word;

  // Byte lane and word position inside the current block.
  assign lane    = fill_r[1:0];
  assign wi      = fill_r[5:2];
  assign lane_sh = {lane, 3'b000};

  assign in_tready = (fst_r == F_ACCEPT) && !q_full;

  // Word with the incoming byte dropped into its lane.
  always_comb begin
    byte_word = word_r;
    byte_word[lane_sh +: 8] = in_tdata;
  end

  // Partial word closed by the padding byte.
  assign keep_mask = (32'd1 << lane_sh) - 32'd1;
  assign pad_word  = {24'd0, PAD_BYTE} << lane_sh;

  // Byte intake and the padding sequencer.
  always_comb begin
    fst_nxt    = fst_r;
    fill_nxt   = fill_r;
    bitlen_nxt = bitlen_r;
    word_nxt   = word_r;
    mark_nxt   = mark_r;
    len_ok_nxt = len_ok_r;
    q_push     = 1'b0;
    q_word     = '0;
    unique case (fst_r)
      F_ACCEPT: begin
        if (in_tvalid && in_tready) begin
          if (in_tuser) begin
            word_nxt   = byte_word;
            fill_nxt   = fill_r + 6'd1;
            bitlen_nxt = bitlen_r + 64'd8;
            if (lane == 2'd3) begin
              q_push      = 1'b1;
              q_word.word = byte_word;
            end
          end
          if (in_tlast) begin
            fst_nxt    = F_PAD;
            mark_nxt   = 1'b0;
            len_ok_nxt = 1'b0;
          end
        end
      end
      F_PAD: begin
        if (!q_full) begin
          q_push   = 1'b1;
          fill_nxt = {wi + 4'd1, 2'b00};
          if (!mark_r) begin
            // The length fits in this block only if the marker lands before word 14.
            q_word.word = (word_r & keep_mask) | pad_word;
            mark_nxt    = 1'b1;
            len_ok_nxt  = (wi < 4'd14) || (wi == 4'd15);
          end else if (len_ok_r && (wi == 4'd14)) begin
            q_word.word = bitlen_r[31:0];
          end else if (len_ok_r && (wi == 4'd15)) begin
            q_word.word    = bitlen_r[63:32];
            q_word.msg_end = 1'b1;
            fst_nxt        = F_ACCEPT;
            fill_nxt       = '0;
            bitlen_nxt     = '0;
          end else begin
            q_word.word = '0;
            if (wi == 4'd15) begin
              len_ok_nxt = 1'b1;
            end
          end
        end
      end
      default: begin
        fst_nxt = F_ACCEPT;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fst_r    <= F_ACCEPT;
      fill_r   <= '0;
      bitlen_r <= '0;
      mark_r   <= 1'b0;
      len_ok_r <= 1'b0;
    end else begin
      fst_r    <= fst_nxt;
      fill_r   <= fill_nxt;
      bitlen_r <= bitlen_nxt;
      mark_r   <= mark_nxt;
      len_ok_r <= len_ok_nxt;
    end
  end

  // Word assembly register.
  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

endmodule

// ===== sv/md5_fifo.sv =====
// Short word queue that decouples the front end from the compressor.
module md5_fifo import md5_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  md5_word_t din,
  output logic      full,
  input  logic      pop,
  output logic      valid,
  output md5_word_t dout
);

  md5_word_t          mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_PTR_W:0]   cnt_r;

  assign full  = (cnt_r == (Q_PTR_W + 1)'(Q_DEPTH));
  assign valid = (cnt_r != '0);
  assign dout  = mem_r[rd_ptr_r];

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

// ===== sv/md5_back.sv =====
// Back end: double-buffered block store, one-round-per-cycle compressor, digest output.
module md5_back import md5_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  md5_word_t   q_head,
  output logic        q_pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] digest_word
  output logic [1:0]  out_tuser,  // [1:0] word_index
  output logic        out_tlast   // final_word
);

  typedef enum logic [4:0] {
    C_IDLE  = 5'b00001,
    C_PREP  = 5'b00010,
    C_ROUND = 5'b00100,
    C_FOLD  = 5'b01000,
    C_EMIT  = 5'b10000
  } cst_t;

  // Two banks of sixteen words, bank select in the top address bit.
  logic [31:0] wbuf_r [32];
  logic [1:0]  bank_full_r, bank_full_nxt;
  logic [1:0]  bank_last_r, bank_last_nxt;
  logic        wr_bank_r, wr_bank_nxt;
  logic        rd_bank_r, rd_bank_nxt;
  logic [3:0]  ld_cnt_r, ld_cnt_nxt;

  cst_t        cst_r, cst_nxt;
  logic [5:0]  rnd_r, rnd_nxt;
  logic [31:0] a_r, b_r, c_r, d_r;
  logic [31:0] a_nxt, b_nxt, c_nxt, d_nxt;
  logic [31:0] kw_r, kw_nxt;
  logic [31:0] chain_r [4];
  logic [31:0] chain_nxt [4];
  logic [1:0]  oidx_r, oidx_nxt;

  logic [5:0]  fetch_rnd;
  logic [31:0] f_val;
  logic [31:0] t_val;
  logic [63:0] rot64;

  // Loader takes words while its bank is free.
  assign q_pop = q_valid && !bank_full_r[wr_bank_r];

  always_ff @(posedge clk) begin
    if (q_pop) begin
      wbuf_r[{wr_bank_r, ld_cnt_r}] <= q_head.word;
    end
  end

  // Next round's constant plus message word, prefetched into a register ahead of its round.
  assign fetch_rnd = (cst_r == C_PREP) ? 6'd0 : (rnd_r + 6'd1);
  assign kw_nxt    = MD5_K[fetch_rnd] + wbuf_r[{rd_bank_r, md5_msg_idx(fetch_rnd)}];

  // Round function of the current group.
  always_comb begin
    case (rnd_r[5:4])
      2'd0:    f_val = d_r ^ (b_r & (c_r ^ d_r));
      2'd1:    f_val = c_r ^ (d_r & (b_r ^ c_r));
      2'd2:    f_val = b_r ^ c_r ^ d_r;
      default: f_val = c_r ^ (b_r | ~d_r);
    endcase
  end

  assign t_val = a_r + f_val + kw_r;
  assign rot64 = {t_val, t_val} << MD5_S[{rnd_r[5:4], rnd_r[1:0]}];

  // Bank bookkeeping and the compression sequencer.
  always_comb begin
    bank_full_nxt = bank_full_r;
    bank_last_nxt = bank_last_r;
    wr_bank_nxt   = wr_bank_r;
    rd_bank_nxt   = rd_bank_r;
    ld_cnt_nxt    = ld_cnt_r;
    cst_nxt       = cst_r;
    rnd_nxt       = rnd_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    c_nxt         = c_r;
    d_nxt         = d_r;
    chain_nxt     = chain_r;
    oidx_nxt      = oidx_r;

    if (q_pop) begin
      ld_cnt_nxt = ld_cnt_r + 4'd1;
      if (ld_cnt_r == 4'd15) begin
        bank_full_nxt[wr_bank_r] = 1'b1;
        bank_last_nxt[wr_bank_r] = q_head.msg_end;
        wr_bank_nxt              = !wr_bank_r;
      end
    end

    unique case (cst_r)
      C_IDLE: begin
        if (bank_full_r[rd_bank_r]) begin
          a_nxt   = chain_r[0];
          b_nxt   = chain_r[1];
          c_nxt   = chain_r[2];
          d_nxt   = chain_r[3];
          cst_nxt = C_PREP;
        end
      end
      C_PREP: begin
        rnd_nxt = '0;
        cst_nxt = C_ROUND;
      end
      C_ROUND: begin
        a_nxt   = d_r;
        d_nxt   = c_r;
        c_nxt   = b_r;
        b_nxt   = b_r + rot64[63:32];
        rnd_nxt = rnd_r + 6'd1;
        if (rnd_r == 6'd63) begin
          cst_nxt = C_FOLD;
        end
      end
      C_FOLD: begin
        chain_nxt[0]             = chain_r[0] + a_r;
        chain_nxt[1]             = chain_r[1] + b_r;
        chain_nxt[2]             = chain_r[2] + c_r;
        chain_nxt[3]             = chain_r[3] + d_r;
        bank_full_nxt[rd_bank_r] = 1'b0;
        rd_bank_nxt              = !rd_bank_r;
        if (bank_last_r[rd_bank_r]) begin
          oidx_nxt = '0;
          cst_nxt  = C_EMIT;
        end else begin
          cst_nxt = C_IDLE;
        end
      end
      C_EMIT: begin
        if (out_tready) begin
          oidx_nxt = oidx_r + 2'd1;
          if (oidx_r == 2'd3) begin
            chain_nxt = MD5_IV;
            cst_nxt   = C_IDLE;
          end
        end
      end
      default: begin
        cst_nxt = C_IDLE;
      end
    endcase
  end

  // Digest words straight from the chaining registers.
  assign out_tvalid = (cst_r == C_EMIT);
  assign out_tdata  = chain_r[oidx_r];
  assign out_tuser  = oidx_r;
  assign out_tlast  = (oidx_r == 2'd3);

  // Control state and chaining values.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_full_r <= '0;
      bank_last_r <= '0;
      wr_bank_r   <= 1'b0;
      rd_bank_r   <= 1'b0;
      ld_cnt_r    <= '0;
      cst_r       <= C_IDLE;
      rnd_r       <= '0;
      oidx_r      <= '0;
      chain_r     <= MD5_IV;
    end else begin
      bank_full_r <= bank_full_nxt;
      bank_last_r <= bank_last_nxt;
      wr_bank_r   <= wr_bank_nxt;
      rd_bank_r   <= rd_bank_nxt;
      ld_cnt_r    <= ld_cnt_nxt;
      cst_r       <= cst_nxt;
      rnd_r       <= rnd_nxt;
      oidx_r      <= oidx_nxt;
      chain_r     <= chain_nxt;
    end
  end

  // Working variables and the prefetched round operand.
  always_ff @(posedge clk) begin
    a_r  <= a_nxt;
    b_r  <= b_nxt;
    c_r  <= c_nxt;
    d_r  <= d_nxt;
    kw_r <= kw_nxt;
  end

endmodule

// ===== sv/md5_hash_engine.sv =====
// Top level of the streaming MD5 engine: front end, word queue and compressor.
// Bytes are taken one per cycle while the front end is not padding and the word queue has room.
// Each full 64-byte block passes the round unit as start, operand fetch, 64 rounds and
// fold; while one bank is being compressed, the loader fills the other.
// A last item adds up to 18 padding words plus one or two blocks, then 4 digest words.
// Synchronous active-low reset clears control state and loads the initial chain.
module md5_hash_engine import md5_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // has_byte
  input  logic        in_tlast,   // last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] digest_word
  output logic [1:0]  out_tuser,  // [1:0] word_index
  output logic        out_tlast   // final_word
);

  logic      q_push;
  logic      q_full;
  logic      q_pop;
  logic      q_valid;
  md5_word_t q_in;
  md5_word_t q_head;

  md5_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .q_push    (q_push),
    .q_word    (q_in),
    .q_full    (q_full)
  );

  md5_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_in),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .dout  (q_head)
  );

  md5_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // The front end never writes into a full queue.
  assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
    else $error("word pushed into a full queue");

  // The compressor only takes words that are present.
  assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
    else $error("word popped from an empty queue");

  // Digest words follow one another in index order.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !out_tlast) |=>
      (out_tvalid && (out_tuser == $past(out_tuser) + 2'd1)))
    else $error("digest word sequence broken");

  // After the final digest word the output goes quiet.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> !out_tvalid)
    else $error("output still valid after final digest word");

endmodule

// ===== test/tb_top.sv =====
// Testbench for the streaming MD5 engine: directed and random messages checked word by word.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import md5_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 300;
  localparam int BLOCK_BYTES  = 64;
  localparam int LEN_POS      = 56;

  // One digest word as the engine should deliver it.
  typedef struct {
    logic [31:0] word;
    logic [1:0]  idx;
    logic        fin;
  } digest_word_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;  // [7:0] data_byte
  logic        in_tuser   = 1'b0;   // has_byte
  logic        in_tlast   = 1'b0;   // last
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;           // [31:0] digest_word
  logic [1:0]  out_tuser;           // [1:0] word_index
  logic        out_tlast;           // final_word

  // Digest model state.
  logic [31:0] hash_chain [4];
  logic [7:0]  block_bytes [BLOCK_BYTES];
  int          fill_bytes;
  logic [63:0] msg_bits;

  digest_word_t pending_digest [$];

  int tx_idle_pct   = 12;
  int rx_idle_pct   = 76;
  int error_count   = 0;
  int words_checked = 0;
  int msgs_sent     = 0;
  int bytes_sent    = 0;
  int cycle_count   = 0;

  md5_hash_engine DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d digest words outstanding.",
               cycle_count, pending_digest.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // Returns the chaining words and the byte buffer to the start of a message.
  function automatic void clear_digest_state();
    for (int i = 0; i < 4; i++) hash_chain[i] = MD5_IV[i];
    fill_bytes = 0;
    msg_bits   = '0;
  endfunction

  // Folds the 64 buffered bytes into the chaining words.
  function automatic void compress_buffer();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, f, t;
    int          g;
    int          s;
    for (int i = 0; i < 16; i++) begin
      w[i] = {block_bytes[4*i+3], block_bytes[4*i+2], block_bytes[4*i+1], block_bytes[4*i]};
    end
    a = hash_chain[0];
    b = hash_chain[1];
    c = hash_chain[2];
    d = hash_chain[3];
    for (int r = 0; r < 64; r++) begin
      case (r / 16)
        0: begin
          f = d ^ (b & (c ^ d));
          g = r;
        end
        1: begin
          f = c ^ (d & (b ^ c));
          g = (5 * r + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          g = (3 * r + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          g = (7 * r) % 16;
        end
      endcase
      t = a + f + MD5_K[r] + w[g];
      s = MD5_S[(r / 16) * 4 + r % 4];
      a = d;
      d = c;
      c = b;
      b = b + ((t << s) | (t >> (32 - s)));
    end
    hash_chain[0] += a;
    hash_chain[1] += b;
    hash_chain[2] += c;
    hash_chain[3] += d;
  endfunction

  // Applies one accepted request to the digest model and queues any digest words.
  function automatic void predict_digest(input logic [7:0] data, input logic has, input logic lst);
    digest_word_t dw;
    if (has) begin
      block_bytes[fill_bytes] = data;
      fill_bytes++;
      msg_bits += 64'd8;
      if (fill_bytes == BLOCK_BYTES) begin
        compress_buffer();
        fill_bytes = 0;
      end
    end
    if (!lst) return;
    // Padding: marker byte, zeros, then the little-endian bit count.
    block_bytes[fill_bytes] = PAD_BYTE;
    fill_bytes++;
    if (fill_bytes > LEN_POS) begin
      while (fill_bytes < BLOCK_BYTES) block_bytes[fill_bytes++] = 8'h00;
      compress_buffer();
      fill_bytes = 0;
    end
    while (fill_bytes < LEN_POS) block_bytes[fill_bytes++] = 8'h00;
    for (int i = 0; i < 8; i++) block_bytes[LEN_POS + i] = msg_bits[8*i +: 8];
    compress_buffer();
    for (int k = 0; k < 4; k++) begin
      dw.word = hash_chain[k];
      dw.idx  = k[1:0];
      dw.fin  = (k == 3);
      pending_digest.push_back(dw);
    end
    clear_digest_state();
  endfunction

  // Compares one delivered digest word with the oldest expected one.
  function automatic void check_digest_word();
    digest_word_t want;
    if (pending_digest.size() == 0) begin
      $display("%0t: unexpected digest word, expected none, actual %h idx %0d last %0b",
               $time, out_tdata, out_tuser, out_tlast);
      error_count++;
      return;
    end
    want = pending_digest.pop_front();
    words_checked++;
    if (out_tdata !== want.word) begin
      $display("%0t: digest_word expected %h actual %h", $time, want.word, out_tdata);
      error_count++;
    end
    if (out_tuser !== want.idx) begin
      $display("%0t: word_index expected %0d actual %0d", $time, want.idx, out_tuser);
      error_count++;
    end
    if (out_tlast !== want.fin) begin
      $display("%0t: final_word expected %0b actual %0b", $time, want.fin, out_tlast);
      error_count++;
    end
  endfunction

  // Result side: check every accepted word and stall at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) check_digest_word();
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Sends one request, with random idle cycles ahead of it, and waits for acceptance.
  task automatic send_item(input logic [7:0] data, input logic has, input logic lst);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'($urandom_range(255));
      in_tuser  <= 1'($urandom_range(1));
      in_tlast  <= 1'($urandom_range(1));
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tuser  <= has;
    in_tlast  <= lst;
    do @(posedge clk); while (!in_tready);
    predict_digest(data, has, lst);
    if (has) bytes_sent++;
    if (lst) msgs_sent++;
  endtask

  // Message lengths: short, so each random phase holds several messages.
  function automatic int pick_msg_len();
    return int'($urandom_range(12));
  endfunction

  // Empty messages, back to back, with junk on the unused data byte.
  task automatic test_empty_message();
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hFF, 1'b0, 1'b1);
  endtask

  // Byte extremes, last on a byte and last alone, and items that carry nothing.
  task automatic test_short_messages();
    send_item(8'hFF, 1'b0, 1'b0);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h5A, 1'b0, 1'b0);
    send_item(8'h80, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'hA5, 1'b0, 1'b1);
    // The classic three-byte message.
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
  endtask

  // A 56-byte message leaves no room for the length, so padding spills into a second block.
  task automatic test_padding_spill();
    for (int i = 0; i < LEN_POS; i++) begin
      send_item(8'($urandom_range(255)), 1'b1, (i == LEN_POS - 1));
    end
  endtask

  // Random messages with stray empty requests mixed in. The 64-bit length
  // wrap would need 2^61 bytes and is out of reach in simulation.
  task automatic test_random_messages(input int tx_pct, input int rx_pct, input int budget);
    int  sent;
    int  len;
    bit  last_on_byte;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    sent = 0;
    while (sent < budget) begin
      len = pick_msg_len();
      if (len > budget - sent) len = budget - sent;
      last_on_byte = (len != 0) && ($urandom_range(1) == 1);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(9) == 0) begin
          send_item(8'($urandom_range(255)), 1'b0, 1'b0);
          sent++;
        end
        send_item(8'($urandom_range(255)), 1'b1, last_on_byte && (i == len - 1));
      end
      if (!last_on_byte) send_item(8'($urandom_range(255)), 1'b0, 1'b1);
      sent += len + (last_on_byte ? 0 : 1);
    end
  endtask

  initial begin
    clear_digest_state();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_message();
    test_short_messages();
    test_padding_spill();
    test_random_messages(12, 76, 14);
    test_random_messages(76, 12, 14);
    test_random_messages(0, 0, 14);

    in_tvalid <= 1'b0;
    while (pending_digest.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Hashed %0d messages from %0d bytes; %0d digest words compared.",
             msgs_sent, bytes_sent, words_checked);
    $display("Stall modes: light sender gaps, heavy sender gaps, and full rate.");
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== md5_hash_engine.f =====
sv/md5_pkg.sv
sv/md5_front.sv
sv/md5_fifo.sv
sv/md5_back.sv
sv/md5_hash_engine.sv
test/tb_top.sv
